[sv/apu_pkg.sv]
// shared types and constants for the adam parameter update block
`timescale 1ns / 1ps
package apu_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_LEARNING_RATE  = 2'd0,
		CFG_FIRST_DECAY    = 2'd1,
		CFG_SECOND_DECAY   = 2'd2,
		CFG_STABILITY_TERM = 2'd3
	} cfg_index_t;

	// register reset values
	localparam logic [23:0] LR_RESET     = 24'd16777;
	localparam logic [23:0] B1_RESET     = 24'd15099494;
	localparam logic [23:0] B2_RESET     = 24'd16760438;
	localparam logic [31:0] EPS_RESET    = 32'd43;

	// one in q1.32 and one in q1.24
	localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
	localparam logic [24:0] ONE_Q24      = 25'h100_0000;

	// largest update step magnitude
	localparam logic [32:0] DELTA_CAP    = 33'h1_0000_0000;

	localparam logic [31:0] STEP_MAX     = 32'hFFFF_FFFF;

	// widths of the shared serial units
	localparam int DIV_W  = 41;
	localparam int ROOT_W = 40;

	// request into the serial divider: ({top, low}) / divisor
	typedef struct packed {
		logic [DIV_W-1:0] top;
		logic [63:0]      low;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

endpackage

[sv/apu_div.sv]
// bit-serial restoring divider, 64 quotient bits, flags overflow
`timescale 1ns / 1ps
module apu_div import apu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  div_req_t    req,
	output logic        done,
	output logic        ovf,
	output logic [63:0] quot
);

	logic             busy_q;
	logic             done_q;
	logic             ovf_q;
	logic [5:0]       cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;
	logic [63:0]      low_q;
	logic [63:0]      quot_q;
	logic [DIV_W:0]   r2;
	logic [DIV_W:0]   diff;
	logic             ge;

	// one trial subtraction per cycle
	always_comb begin
		r2   = {rem_q, low_q[63]};
		diff = r2 - {1'b0, div_q};
		ge   = (r2 >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				// quotient too large for 64 bits
				if (req.top >= req.divisor) begin
					ovf_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					ovf_q  <= 1'b0;
					busy_q <= 1'b1;
					rem_q  <= req.top;
					low_q  <= req.low;
					div_q  <= req.divisor;
					quot_q <= '0;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				rem_q  <= ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
				low_q  <= {low_q[62:0], 1'b0};
				quot_q <= {quot_q[62:0], ge};
				cnt_q  <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quot = quot_q;

endmodule

[sv/apu_sqrt.sv]
// digit-by-digit integer square root, one root bit per cycle
`timescale 1ns / 1ps
module apu_sqrt import apu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2*ROOT_W-1:0] radicand,
	output logic                done,
	output logic [ROOT_W-1:0]   root
);

	logic                busy_q;
	logic                done_q;
	logic [5:0]          cnt_q;
	logic [ROOT_W+1:0]   rem_q;
	logic [2*ROOT_W-1:0] rad_q;
	logic [ROOT_W-1:0]   root_q;
	logic [ROOT_W+3:0]   r2;
	logic [ROOT_W+3:0]   trial;
	logic                ge;

	// bring down two radicand bits, try root*4+1
	always_comb begin
		r2    = {rem_q, rad_q[2*ROOT_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		ge    = (r2 >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				rem_q  <= '0;
				root_q <= '0;
				rad_q  <= radicand;
				cnt_q  <= '0;
			end else if (busy_q) begin
				rem_q  <= ge ? (ROOT_W+2)'(r2 - trial) : (ROOT_W+2)'(r2);
				root_q <= {root_q[ROOT_W-2:0], ge};
				rad_q  <= {rad_q[2*ROOT_W-3:0], 2'b00};
				cnt_q  <= cnt_q + 6'd1;
				if (cnt_q == 6'(ROOT_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[sv/adam_parameter_update.sv]
// adam parameter update: moment memories, step state and update sequencer
// an item with no step begun or an index out of range passes its param through; an item that
//   begins a step first advances the decay powers; a full update runs the serial divider up to
//   three times, the square root once and a multiply sequence; divider overflow shortens it
// throughput: one item at a time; the next item is taken while the result waits
// reset: after arst_n the moment memories are cleared, one entry per cycle,
//   with s_axis_tready low throughout the pass; configuration writes are taken
`timescale 1ns / 1ps
module adam_parameter_update import apu_pkg::*; #(
	parameter int NUM_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // element_index, param_value, gradient_value, zero pad
	input  logic        s_axis_tuser,  // first_of_step
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // new_param, step_number
	output logic        m_axis_tuser   // saturated
);

	localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int XW = AW + 10;

	typedef enum logic [4:0] {
		S_IDLE, S_POW1, S_POW2, S_POW3, S_CHECK,
		S_M1, S_M2, S_M3, S_V1, S_V2, S_G, S_G1, S_G2, S_G3, S_WB, S_WR,
		S_DIV1, S_DIV2, S_SQRT, S_L1, S_L2, S_L3, S_QS, S_DIV3, S_RES, S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [23:0] lr_q;
	logic [23:0] b1_q;
	logic [23:0] b2_q;
	logic [31:0] eps_q;

	// step state
	logic [31:0] step_q;
	logic [32:0] pow1_q;
	logic [32:0] pow2_q;

	// clearing pass
	logic          clearing_q;
	logic [AW:0]   clr_cnt_q;

	// item registers
	logic [AW-1:0]      addr_q;
	logic               in_range_q;
	logic signed [31:0] param_q;
	logic signed [31:0] grad_q;

	// working registers
	logic signed [67:0] acc_q;
	logic signed [47:0] m_new_q;
	logic [63:0]        vacc_q;
	logic [63:0]        sq_q;
	logic [63:0]        mh_q;
	logic [DIV_W-1:0]   den_q;
	logic [87:0]        num_q;
	logic [32:0]        q_q;
	logic [31:0]        res_q;
	logic               sat_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_param_q;
	logic [31:0] out_step_q;
	logic        out_sat_q;

	// memories
	logic [47:0] m_mem [NUM_ENTRIES];
	logic [63:0] v_mem [NUM_ENTRIES];
	logic [47:0] m_rd_q;
	logic [63:0] v_rd_q;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [47:0] m_wdata;
	logic [63:0] v_wdata;

	// multiplier
	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [67:0] prod_q;

	// serial units
	logic        div_start;
	div_req_t    div_req;
	logic        div_done;
	logic        div_ovf;
	logic [63:0] div_quot;
	logic        sqrt_start;
	logic [79:0] sqrt_rad;
	logic        sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;

	// decoded input and helpers
	logic [9:0]   in_index;
	logic [XW-1:0] in_index_w;
	logic          accept;
	logic [24:0]  c1d;
	logic [24:0]  c2d;
	logic [31:0]  ag;
	logic [47:0]  am;
	logic [32:0]  c1;
	logic [32:0]  c2;
	logic [63:0]  vh_sel;
	logic signed [34:0] sum_res;

	assign in_index   = s_axis_tdata[9:0];
	assign in_index_w = XW'(in_index);
	assign s_axis_tready = (state_q == S_IDLE) && !clearing_q;
	assign accept     = s_axis_tvalid && s_axis_tready;

	// derived operands
	always_comb begin
		c1d = ONE_Q24 - {1'b0, b1_q};
		c2d = ONE_Q24 - {1'b0, b2_q};
		ag  = grad_q[31] ? 32'(-grad_q) : 32'(grad_q);
		am  = m_new_q[47] ? 48'(-m_new_q) : 48'(m_new_q);
		c1  = ONE_Q32 - pow1_q;
		c2  = ONE_Q32 - pow2_q;
		if (c1 == '0) c1 = 33'd1;
		if (c2 == '0) c2 = 33'd1;
		vh_sel = div_ovf ? '1 : div_quot;
		sum_res = m_new_q[47] ? (35'(param_q) + $signed({2'b00, q_q}))
		                      : (35'(param_q) - $signed({2'b00, q_q}));
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= LR_RESET;
			b1_q  <= B1_RESET;
			b2_q  <= B2_RESET;
			eps_q <= EPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEARNING_RATE:  lr_q  <= cfg_data[23:0];
				CFG_FIRST_DECAY:    b1_q  <= cfg_data[23:0];
				CFG_SECOND_DECAY:   b2_q  <= cfg_data[23:0];
				CFG_STABILITY_TERM: eps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_POW1: begin mul_a = 34'(pow1_q);            mul_b = 34'(b1_q); end
			S_POW2: begin mul_a = 34'(pow2_q);            mul_b = 34'(b2_q); end
			S_M1:   begin mul_a = 34'(m_rd_q[23:0]);      mul_b = 34'(b1_q); end
			S_M2:   begin mul_a = 34'(c1d);               mul_b = 34'(grad_q); end
			S_M3:   begin mul_a = 34'($signed(m_rd_q[47:24])); mul_b = 34'(b1_q); end
			S_V1:   begin mul_a = 34'(v_rd_q[63:32]);     mul_b = 34'(b2_q); end
			S_V2:   begin mul_a = 34'(v_rd_q[31:0]);      mul_b = 34'(b2_q); end
			S_G:    begin mul_a = 34'(ag);                mul_b = 34'(ag); end
			S_G2:   begin mul_a = 34'(sq_q[63:32]);       mul_b = 34'(c2d); end
			S_G3:   begin mul_a = 34'(sq_q[31:0]);        mul_b = 34'(c2d); end
			S_L1:   begin mul_a = 34'(mh_q[31:0]);        mul_b = 34'(lr_q); end
			S_L2:   begin mul_a = 34'(mh_q[63:32]);       mul_b = 34'(lr_q); end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// memory write source: clearing pass or write-back
	always_comb begin
		mem_we    = clearing_q || (state_q == S_WR && in_range_q);
		mem_waddr = clearing_q ? clr_cnt_q[AW-1:0] : addr_q;
		m_wdata   = clearing_q ? '0 : m_new_q;
		v_wdata   = clearing_q ? '0 : vacc_q;
	end

	// moment memories, read on accept
	always_ff @(posedge clk) begin
		if (mem_we) begin
			m_mem[mem_waddr] <= m_wdata;
			v_mem[mem_waddr] <= v_wdata;
		end
		if (accept) begin
			m_rd_q <= m_mem[in_index_w[AW-1:0]];
			v_rd_q <= v_mem[in_index_w[AW-1:0]];
		end
	end

	// serial unit requests
	always_comb begin
		div_start  = 1'b0;
		div_req    = '0;
		sqrt_start = 1'b0;
		sqrt_rad   = {vh_sel, 16'b0};
		case (state_q)
			S_WR: begin
				div_start       = 1'b1;
				div_req.top     = DIV_W'(am[47:32]);
				div_req.low     = {am[31:0], 32'b0};
				div_req.divisor = DIV_W'(c1);
			end
			S_DIV1: begin
				div_start       = div_done;
				div_req.top     = DIV_W'(vacc_q[63:32]);
				div_req.low     = {vacc_q[31:0], 32'b0};
				div_req.divisor = DIV_W'(c2);
			end
			S_DIV2: sqrt_start = div_done;
			S_QS: begin
				div_start       = (den_q != '0);
				div_req.top     = DIV_W'(num_q[87:64]);
				div_req.low     = num_q[63:0];
				div_req.divisor = den_q;
			end
			default: ;
		endcase
	end

	apu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.done   (div_done),
		.ovf    (div_ovf),
		.quot   (div_quot)
	);

	apu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sqrt_rad),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// update sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clearing_q  <= 1'b1;
			clr_cnt_q   <= '0;
			step_q      <= '0;
			pow1_q      <= ONE_Q32;
			pow2_q      <= ONE_Q32;
			out_valid_q <= 1'b0;
		end else begin
			// clearing pass after reset
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (AW+1)'(NUM_ENTRIES - 1)) clearing_q <= 1'b0;
			end

			// result taken with no new one to load
			if (out_valid_q && m_axis_tready && state_q != S_DONE) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q     <= in_index_w[AW-1:0];
						in_range_q <= (in_index_w < XW'(NUM_ENTRIES));
						param_q    <= $signed(s_axis_tdata[41:10]);
						grad_q     <= $signed(s_axis_tdata[73:42]);
						if (s_axis_tuser && step_q != STEP_MAX) begin
							step_q  <= step_q + 32'd1;
							state_q <= S_POW1;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				// decay powers advance
				S_POW1: state_q <= S_POW2;
				S_POW2: begin
					pow1_q  <= prod_q[56:24];
					state_q <= S_POW3;
				end
				S_POW3: begin
					pow2_q  <= prod_q[56:24];
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (step_q != '0 && in_range_q) begin
						state_q <= S_M1;
					end else begin
						res_q   <= param_q;
						sat_q   <= 1'b0;
						state_q <= S_DONE;
					end
				end
				// first moment
				S_M1: state_q <= S_M2;
				S_M2: begin
					acc_q   <= prod_q;
					state_q <= S_M3;
				end
				S_M3: begin
					acc_q   <= acc_q + (prod_q <<< 8);
					state_q <= S_V1;
				end
				// second moment
				S_V1: begin
					m_new_q <= 48'((acc_q >>> 24) + prod_q);
					state_q <= S_V2;
				end
				S_V2: begin
					vacc_q  <= {prod_q[55:0], 8'b0};
					state_q <= S_G;
				end
				S_G: begin
					vacc_q  <= vacc_q + 64'(prod_q[67:24]);
					state_q <= S_G1;
				end
				S_G1: begin
					sq_q    <= prod_q[63:0];
					state_q <= S_G2;
				end
				S_G2: state_q <= S_G3;
				S_G3: begin
					vacc_q  <= vacc_q + {prod_q[55:0], 8'b0};
					state_q <= S_WB;
				end
				S_WB: begin
					vacc_q  <= vacc_q + 64'(prod_q[67:24]);
					state_q <= S_WR;
				end
				// write back and start m-hat division
				S_WR: state_q <= S_DIV1;
				S_DIV1: begin
					if (div_done) begin
						mh_q    <= div_ovf ? '1 : div_quot;
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_done) state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sqrt_done) begin
						den_q   <= DIV_W'(sqrt_root) + DIV_W'(eps_q);
						state_q <= S_L1;
					end
				end
				// numerator lr * m-hat
				S_L1: state_q <= S_L2;
				S_L2: begin
					num_q   <= 88'(prod_q[55:0]);
					state_q <= S_L3;
				end
				S_L3: begin
					num_q   <= num_q + {prod_q[55:0], 32'b0};
					state_q <= S_QS;
				end
				S_QS: begin
					if (den_q == '0) begin
						q_q     <= (num_q != '0) ? DELTA_CAP : '0;
						state_q <= S_RES;
					end else begin
						state_q <= S_DIV3;
					end
				end
				S_DIV3: begin
					if (div_done) begin
						if (div_ovf || div_quot > 64'(DELTA_CAP)) q_q <= DELTA_CAP;
						else q_q <= div_quot[32:0];
						state_q <= S_RES;
					end
				end
				// apply step and clamp
				S_RES: begin
					if (sum_res > 35'sd2147483647) begin
						res_q <= 32'h7FFF_FFFF;
						sat_q <= 1'b1;
					end else if (sum_res < -35'sd2147483648) begin
						res_q <= 32'h8000_0000;
						sat_q <= 1'b1;
					end else begin
						res_q <= sum_res[31:0];
						sat_q <= 1'b0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_param_q <= res_q;
						out_step_q  <= step_q;
						out_sat_q   <= sat_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_step_q, out_param_q};
	assign m_axis_tuser  = out_sat_q;

endmodule

[tb/sv/adam_parameter_update_test.sv]
// self-checking testbench for the adam parameter update block
`timescale 1ns / 1ps
module adam_parameter_update_test;
	import apu_pkg::*;

	localparam int NUM_ENTRIES = 1024;
	localparam int SETTLE_CYCLES = 400;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [9:0]         idx;
		logic signed [31:0] param;
		logic signed [31:0] grad;
		logic               first;
	} elem_item_t;

	typedef struct {
		logic [31:0] new_param;
		logic [31:0] step_num;
		logic        sat;
	} update_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [79:0] s_axis_tdata = '0;  // element_index, param_value, gradient_value, zero pad
	logic s_axis_tuser = 1'b0;       // first_of_step
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;       // new_param, step_number
	logic m_axis_tuser;              // saturated

	adam_parameter_update #(.NUM_ENTRIES(NUM_ENTRIES)) uut (.*);

	always #1 clk = ~clk;

	// predictor state
	logic [23:0] lr_q, b1_q, b2_q;
	logic [31:0] eps_q;
	logic signed [47:0] mom1 [NUM_ENTRIES];
	logic [63:0] mom2 [NUM_ENTRIES];
	logic [31:0] steps;
	logic [32:0] pow1, pow2;

	elem_item_t pending_items[$];
	update_t expected_updates[$];
	elem_item_t cur_item;
	int unsigned fails = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_gap = 0, recv_gap = 0;
	bit idling_on = 1'b1;

	// floor(a * 2^32 / c), saturating to 64 bits
	function automatic logic [63:0] bias_div(logic [63:0] a, logic [32:0] c);
		logic [127:0] q;
		q = {32'd0, a, 32'd0} / {95'd0, c};
		return (q[127:64] != 0) ? '1 : q[63:0];
	endfunction

	function automatic update_t adam_update(elem_item_t it);
		update_t r;
		logic signed [127:0] acc, res;
		logic [127:0] ag, vw, rad, t, num, q;
		logic [63:0] mh, vh, sroot, den;
		logic [32:0] c1, c2;
		logic signed [47:0] m;
		if (it.first && steps != STEP_MAX) begin
			steps++;
			pow1 = 33'(({95'd0, pow1} * b1_q) >> 24);
			pow2 = 33'(({95'd0, pow2} * b2_q) >> 24);
		end
		res = it.param;
		r.sat = 1'b0;
		if (steps != 0 && it.idx < NUM_ENTRIES) begin
			acc = 128'(mom1[it.idx]) * $signed({104'd0, b1_q})
				+ $signed(128'(ONE_Q24 - b1_q)) * (128'(it.grad) * 256);
			m = 48'(acc >>> 24);
			ag = (it.grad < 0) ? 128'(-128'(it.grad)) : 128'(it.grad);
			vw = (({64'd0, mom2[it.idx]} * b2_q) >> 24)
				+ ((ag * ag * (ONE_Q24 - b2_q)) >> 24);
			mom1[it.idx] = m;
			mom2[it.idx] = vw[63:0];
			c1 = ONE_Q32 - pow1;
			c2 = ONE_Q32 - pow2;
			if (c1 == 0) c1 = 33'd1;
			if (c2 == 0) c2 = 33'd1;
			mh = bias_div(64'((m < 0) ? -128'(m) : 128'(m)), c1);
			vh = bias_div(vw[63:0], c2);
			// integer square root of vh * 2^16
			rad = {48'd0, vh, 16'd0};
			sroot = '0;
			for (int b = 63; b >= 0; b--) begin
				t = {64'd0, sroot | (64'd1 << b)};
				if (t * t <= rad) sroot = t[63:0];
			end
			den = sroot + eps_q;
			num = {64'd0, mh} * lr_q;
			if (den == 0) q = (num != 0) ? 128'(DELTA_CAP) : '0;
			else if (num[127:64] >= den) q = 128'(DELTA_CAP);
			else q = num / den;
			if (q > DELTA_CAP) q = 128'(DELTA_CAP);
			res = (m < 0) ? res + $signed(q) : res - $signed(q);
			if (res > 128'sd2147483647) begin
				res = 128'sd2147483647;
				r.sat = 1'b1;
			end else if (res < -128'sd2147483648) begin
				res = -128'sd2147483648;
				r.sat = 1'b1;
			end
		end
		r.new_param = res[31:0];
		r.step_num = steps;
		return r;
	endfunction

	// sender: presents queued items with random gaps
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			nv = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				expected_updates.push_back(adam_update(cur_item));
				nv = 1'b0;
				if (idling_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 16);
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() > 0) begin
					cur_item <= pending_items[0];
					s_axis_tdata <= {6'd0, pending_items[0].grad, pending_items[0].param,
						pending_items[0].idx};
					s_axis_tuser <= pending_items[0].first;
					void'(pending_items.pop_front());
					nv = 1'b1;
				end
			end
			s_axis_tvalid <= nv;
		end
	end

	// receiver: random stalls and result check
	always @(posedge clk or negedge arst_n) begin
		update_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_updates.size() == 0) begin
					$error("unexpected result item %h", m_axis_tdata);
					fails++;
				end else begin
					e = expected_updates.pop_front();
					if (m_axis_tdata[31:0] !== e.new_param) begin
						$error("new_param expected %h actual %h", e.new_param, m_axis_tdata[31:0]);
						fails++;
					end
					if (m_axis_tdata[63:32] !== e.step_num) begin
						$error("step_number expected %0d actual %0d", e.step_num,
							m_axis_tdata[63:32]);
						fails++;
					end
					if (m_axis_tuser !== e.sat) begin
						$error("saturated expected %b actual %b", e.sat, m_axis_tuser);
						fails++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (idling_on && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 16);
			end
		end
	end

	// watchdog on cycles with no handshake or configuration write
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic queue_item(int idx, int param, int grad, bit first);
		elem_item_t it;
		it.idx = 10'(idx);
		it.param = param;
		it.grad = grad;
		it.first = first;
		pending_items.push_back(it);
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && !s_axis_tvalid && expected_updates.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t ix, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ix;
		cfg_data <= val;
		case (ix)
			CFG_LEARNING_RATE: lr_q = val[23:0];
			CFG_FIRST_DECAY: b1_q = val[23:0];
			CFG_SECOND_DECAY: b2_q = val[23:0];
			CFG_STABILITY_TERM: eps_q = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(logic [31:0] lr, logic [31:0] b1, logic [31:0] b2, logic [31:0] eps);
		write_reg(CFG_LEARNING_RATE, lr);
		write_reg(CFG_FIRST_DECAY, b1);
		write_reg(CFG_SECOND_DECAY, b2);
		write_reg(CFG_STABILITY_TERM, eps);
	endtask

	function automatic int pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return int'($urandom_range(0, 65535)) - 32768;
			default: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
		endcase
	endfunction

	task automatic random_items(int n);
		for (int i = 0; i < n; i++)
			queue_item($urandom_range(0, 3) == 0 ? $urandom_range(0, 999) : $urandom_range(0, 15),
				pick_value(), pick_value(), $urandom_range(0, 7) == 0);
	endtask

	initial begin
		lr_q = LR_RESET;
		b1_q = B1_RESET;
		b2_q = B2_RESET;
		eps_q = EPS_RESET;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			mom1[i] = '0;
			mom2[i] = '0;
		end
		steps = '0;
		pow1 = ONE_Q32;
		pow2 = ONE_Q32;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// no step begun yet, then extremes at reset settings
		queue_item(0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		queue_item(1023, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		queue_item(0, 123456, 1 << 24, 1);
		queue_item(1023, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		queue_item(1, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		queue_item(2, 0, 0, 0);
		queue_item(512, -1, -1, 1);
		queue_item(3, 32'h7FFF_FFFF, -5000, 0);
		queue_item(4, 32'h8000_0000, 5000, 0);
		queue_item(0, 0, 32'h7FFF_FFFF, 1);
		drain();

		// zero denominator on fresh elements
		set_regs(24'hFF_FFFF, 0, 24'hFF_FFFF, 0);
		queue_item(1000, 0, 1, 1);
		queue_item(1001, 0, -1, 0);
		queue_item(1002, 5, 0, 0);
		queue_item(1003, 32'h7FFF_FFFF, -1, 0);
		random_items(140);
		drain();

		set_regs(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
		random_items(140);
		drain();
		set_regs(0, 0, 0, 43);
		random_items(140);
		drain();
		set_regs(24'hFF_FFFF, 0, 0, 0);
		random_items(140);
		drain();
		for (int p = 0; p < 2; p++) begin
			set_regs($urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 24'hFF_FFFF),
				$urandom_range(0, 24'hFF_FFFF), $urandom());
			random_items(140);
			drain();
		end
		set_regs(LR_RESET, B1_RESET, B2_RESET, EPS_RESET);
		random_items(100);
		wait (pending_items.size() == 0);
		// final stretch without idling
		idling_on = 1'b0;
		random_items(80);
		drain();

		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
